// ===== design/ritc_pkg.sv =====
// Package for the range increment / threshold count unit.
// Holds field widths, command and register codes, sequencer states and the sequencer-to-update control struct.
// No dependencies.
package ritc_pkg;

  localparam int unsigned CMD_W          = 2;
  localparam int unsigned INDEX_W        = 10;
  localparam int unsigned LOAD_W         = 32;
  localparam int unsigned COUNT_W        = 11;
  localparam int unsigned THRESH_W       = 32;
  localparam int unsigned USED_LEN_W     = 11;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam logic [USED_LEN_W-1:0] USED_LEN_RESET = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_COUNT = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 2'd0,
    REG_USED_LENGTH = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_WALK = 1'b1
  } seq_state_e;

  // Control from the sequencer to the update stage, valid for one cycle.
  typedef struct packed {
    logic issue;        // a memory read was issued this cycle
    logic add;          // the issued read belongs to an add walk
    logic last;         // the issued read is the last of its range
    logic load;         // write the load value at the given address
    logic count_clear;  // a count walk starts: clear the accumulator
    logic count_empty;  // a count over an empty range: report zero
  } seq_ctl_t;

endpackage

// ===== design/ritc_if.sv =====
// Valid/ready channel interfaces for the range increment / threshold count unit.
// Depends on ritc_pkg for the field widths.
interface ritc_in_if;
  import ritc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [INDEX_W-1:0] first_index;
  logic [INDEX_W-1:0] last_index;
  logic [LOAD_W-1:0]  load_value;

  modport source (output valid, command, first_index, last_index, load_value, input ready);
  modport sink   (input valid, command, first_index, last_index, load_value, output ready);
endinterface

interface ritc_out_if;
  import ritc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] element_count;

  modport source (output valid, element_count, input ready);
  modport sink   (input valid, element_count, output ready);
endinterface

// ===== design/range_increment_threshold_count_unit.sv =====
// Top level of the range increment / threshold count unit.
// Depends on ritc_pkg, ritc_if, ritc_ram, ritc_seq and ritc_update.
//
//   Channel   Direction  Handshake            Payload
//   in_i      sink       valid / ready        command, first_index, last_index, load_value
//   out_o     source     valid / ready        element_count
//   cfg       write      cfg_we_i             cfg_index_i, cfg_data_i
//
// A load writes the element memory in the cycle it is taken, and the next transfer can follow
// at once. An add or a count over a clipped range walks it, issuing one read of the element
// memory per cycle, and the last write-back or count step follows in the cycle after the last
// read. The single read port of the element memory sets this rate. A count result then moves
// into the output register, and the next input is taken once it has done so.
// Reset clears the control state only; element memory contents are undefined until loaded.
// A stalled output holds its count, and only a further count waits for it to drain.
module range_increment_threshold_count_unit #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned VALUE_BITS   = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ritc_in_if.sink                           in_i,
  ritc_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [ritc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ritc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ritc_pkg::*;

  // Address width of the element memory, and a width that holds both the used length
  // register and the element count itself for length comparisons.
  localparam int unsigned AW    = $clog2(MAX_ELEMENTS);
  localparam int unsigned LEN_W = (AW + 1 > USED_LEN_W) ? AW + 1 : USED_LEN_W;

  logic [THRESH_W-1:0]   threshold_q;
  logic [USED_LEN_W-1:0] used_len_q;
  logic [LEN_W-1:0]      used_len_ext;
  logic [LEN_W-1:0]      eff_len;

  seq_ctl_t              ctl;
  logic [AW-1:0]         addr;
  logic                  busy;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [VALUE_BITS-1:0] rdata;

  // Configuration registers. Writes to indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      used_len_q  <= USED_LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_THRESHOLD: begin
          threshold_q <= cfg_data_i[THRESH_W-1:0];
        end
        REG_USED_LENGTH: begin
          used_len_q <= cfg_data_i[USED_LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The effective used length never exceeds the memory depth.
  assign used_len_ext = LEN_W'(used_len_q);
  assign eff_len      = (used_len_ext < LEN_W'(MAX_ELEMENTS)) ? used_len_ext
                                                              : LEN_W'(MAX_ELEMENTS);

  ritc_seq #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEN_W        (LEN_W)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .eff_len_i (eff_len),
    .busy_i    (busy),
    .ctl_o     (ctl),
    .addr_o    (addr)
  );

  ritc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ELEMENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctl.issue),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  ritc_update #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_update (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .addr_i       (addr),
    .load_value_i (in_i.load_value),
    .threshold_i  (threshold_q),
    .rdata_i      (rdata),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .busy_o       (busy),
    .out_o        (out_o)
  );

endmodule

// ===== design/ritc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module ritc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ritc_seq.sv =====
// Sequencer: accepts input transfers, clips the index range and walks the memory addresses.
// Depends on ritc_pkg and ritc_if.
module ritc_seq #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned LEN_W        = 11
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ritc_in_if.sink                         in_i,
  input  logic [LEN_W-1:0]                eff_len_i,
  input  logic                            busy_i,
  output ritc_pkg::seq_ctl_t              ctl_o,
  output logic [$clog2(MAX_ELEMENTS)-1:0] addr_o
);
  import ritc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);

  seq_state_e    state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] hi_q, hi_d;
  logic          add_q, add_d;

  logic             in_ready;
  logic             accept;
  logic [LEN_W-1:0] first_ext;
  logic [LEN_W-1:0] last_ext;
  logic [LEN_W-1:0] hi_ext;
  logic             empty;

  assign in_ready   = (state_q == SEQ_IDLE) && !busy_i;
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // Clip the range end to the used length; an empty range does no memory work.
  assign first_ext = LEN_W'(in_i.first_index);
  assign last_ext  = LEN_W'(in_i.last_index);
  assign hi_ext    = (last_ext > (eff_len_i - LEN_W'(1))) ? (eff_len_i - LEN_W'(1)) : last_ext;
  assign empty     = (eff_len_i == '0) || (first_ext > hi_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    hi_q   <= hi_d;
    add_q  <= add_d;
  end

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    hi_d    = hi_q;
    add_d   = add_q;
    ctl_o   = '0;
    addr_o  = first_ext[AW-1:0];
    case (state_q)
      SEQ_IDLE: begin
        if (accept) begin
          case (cmd_e'(in_i.command))
            CMD_LOAD: begin
              ctl_o.load = first_ext < eff_len_i;
            end
            CMD_ADD: begin
              if (!empty) begin
                state_d = SEQ_WALK;
                addr_d  = first_ext[AW-1:0];
                hi_d    = hi_ext[AW-1:0];
                add_d   = 1'b1;
              end
            end
            CMD_COUNT: begin
              if (empty) begin
                ctl_o.count_empty = 1'b1;
              end else begin
                ctl_o.count_clear = 1'b1;
                state_d = SEQ_WALK;
                addr_d  = first_ext[AW-1:0];
                hi_d    = hi_ext[AW-1:0];
                add_d   = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      SEQ_WALK: begin
        ctl_o.issue = 1'b1;
        ctl_o.add   = add_q;
        ctl_o.last  = (addr_q == hi_q);
        addr_o      = addr_q;
        if (addr_q == hi_q) begin
          state_d = SEQ_IDLE;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

endmodule

// ===== design/ritc_update.sv =====
// Update stage: takes read data from the element memory, writes back saturated increments,
// accumulates the threshold count and holds the result register. Depends on ritc_pkg, ritc_if.
module ritc_update #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned VALUE_BITS   = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  ritc_pkg::seq_ctl_t                     ctl_i,
  input  logic [$clog2(MAX_ELEMENTS)-1:0]        addr_i,
  input  logic [ritc_pkg::LOAD_W-1:0]            load_value_i,
  input  logic [ritc_pkg::THRESH_W-1:0]          threshold_i,
  input  logic [VALUE_BITS-1:0]                  rdata_i,
  output logic                                   we_o,
  output logic [$clog2(MAX_ELEMENTS)-1:0]        waddr_o,
  output logic [VALUE_BITS-1:0]                  wdata_o,
  output logic                                   busy_o,
  ritc_out_if.source                             out_o
);
  import ritc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = (VALUE_BITS > THRESH_W) ? VALUE_BITS : THRESH_W;

  logic          s1_valid_q;
  logic          s1_add_q;
  logic          s1_last_q;
  logic [AW-1:0] s1_addr_q;

  logic               pend_q, pend_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;

  logic [VALUE_BITS-1:0] incr;
  logic                  at_or_above;
  logic                  out_free;

  assign incr        = (rdata_i == '1) ? rdata_i : rdata_i + VALUE_BITS'(1);
  assign at_or_above = CW'(rdata_i) >= CW'(threshold_i);

  // Loads never overlap a write-back: a load is only taken while nothing is in flight.
  assign we_o    = ctl_i.load || (s1_valid_q && s1_add_q);
  assign waddr_o = s1_valid_q ? s1_addr_q : addr_i;
  assign wdata_o = s1_valid_q ? incr : VALUE_BITS'(load_value_i);

  assign busy_o   = s1_valid_q || pend_q;
  assign out_free = !out_valid_q || out_o.ready;

  assign out_o.valid         = out_valid_q;
  assign out_o.element_count = out_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= ctl_i.issue;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_add_q    <= ctl_i.add;
    s1_last_q   <= ctl_i.last;
    s1_addr_q   <= addr_i;
    cnt_q       <= cnt_d;
    out_count_q <= out_count_d;
  end

  always_comb begin
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    if (ctl_i.count_clear) begin
      cnt_d = '0;
    end
    if (ctl_i.count_empty) begin
      cnt_d  = '0;
      pend_d = 1'b1;
    end
    if (s1_valid_q && !s1_add_q) begin
      cnt_d = cnt_q + COUNT_W'(at_or_above);
      if (s1_last_q) begin
        pend_d = 1'b1;
      end
    end
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pend_q && out_free) begin
      out_valid_d = 1'b1;
      out_count_d = cnt_q;
      pend_d      = 1'b0;
    end
  end

endmodule

// ===== design/ritc_checker.sv =====
// Port-level checker for the range increment / threshold count unit, and its bind.
// Depends on ritc_pkg and on the top level range_increment_threshold_count_unit.
module ritc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic [ritc_pkg::CMD_W-1:0]     in_command_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [ritc_pkg::COUNT_W-1:0]   out_count_i
);
  import ritc_pkg::*;

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_i;

  // A stalled result keeps its valid and its count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_count_i))
    else $error("stalled result changed");

  // A count transfer always occupies the block for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_command_i == CMD_COUNT) |=> !in_ready_i)
    else $error("input ready right after a count transfer");

  // A load needs no walk, so the input stays open behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (in_command_i == CMD_LOAD) |=> in_ready_i)
    else $error("input blocked after a load transfer");

  // A new result only appears while a count was in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while the block was idle");

endmodule

bind range_increment_threshold_count_unit ritc_checker u_ritc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_count_i  (out_o.element_count)
);
